// ===== src/salc_pkg.sv =====
// Shared types and constants of the set-associative LRU cache model.
// No dependencies; every other file of the block but salc_ram uses this package.
`timescale 1ns / 1ps
`default_nettype none
package salc_pkg;

  // Fixed field widths.
  localparam int ADDR_W = 32;
  localparam int MODE_W = 2;
  localparam int CNT_W  = 32;

  // Defaults for the top-level parameters.
  localparam int DEF_WAYS       = 4;
  localparam int DEF_SETS       = 128;
  localparam int DEF_LINE_SHIFT = 5;

  // Allocation and prefetch policy codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC    = 2'd0,
    MODE_NO_WA    = 2'd1,
    MODE_PF_ALL   = 2'd2,
    MODE_PF_MISS  = 2'd3
  } mode_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MOD,
    S_UPD,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic accept;
    logic mul1;
    logic mul2;
    logic modr;
    logic update;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic prefetch_req;
    logic demand_phase;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/salc_if.sv =====
// Valid/ready channel interfaces for the request and response items.
// Depends on salc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface salc_req_if;
  logic                      valid;
  logic                      ready;
  logic [salc_pkg::ADDR_W-1:0] address;
  logic                      is_store;

  modport source (output valid, output address, output is_store, input ready);
  modport sink   (input valid, input address, input is_store, output ready);
endinterface

interface salc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic                       demand_filled;
  logic                       prefetch_filled;
  logic [salc_pkg::CNT_W-1:0] hit_count;
  logic [salc_pkg::CNT_W-1:0] access_count;

  modport source (output valid, output hit, output demand_filled, output prefetch_filled,
                  output hit_count, output access_count, input ready);
  modport sink   (input valid, input hit, input demand_filled, input prefetch_filled,
                  input hit_count, input access_count, output ready);
endinterface
`default_nettype wire

// ===== src/set_assoc_lru_cache_prefetch.sv =====
// Top level of the set-associative LRU cache model with next-line prefetch.
// Depends on salc_pkg, salc_if, salc_ctrl and salc_dp.
//
//   channel | dir | handshake        | item contents
//   req     | in  | valid/ready      | address, is_store
//   rsp     | out | valid/ready      | hit, fills, hit_count, access_count
//   cfg     | in  | cfg_we (no wait) | policy_mode
//
// An item runs from its accepting state IDLE through MUL1, MUL2, MOD, UPD to
// DONE, which loads its result, with MUL1 to UPD again when the next line is
// prefetched: each set access is multiply states MUL1 and MUL2 for the set
// index, memory read state MOD and read-modify-write state UPD on the tag RAM.
// After reset a clearing sweep over all SETS rows runs before the first item.
// A result waits in an output register; the next item is taken meanwhile and
// stalls only at its completion until that register is free.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_lru_cache_prefetch #(
  parameter int WAYS       = salc_pkg::DEF_WAYS,
  parameter int SETS       = salc_pkg::DEF_SETS,
  parameter int LINE_SHIFT = salc_pkg::DEF_LINE_SHIFT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  salc_req_if.sink                         req,
  salc_rsp_if.source                       rsp,
  input  wire logic                        cfg_we,
  input  wire logic [salc_pkg::MODE_W-1:0] cfg_wdata
);
  import salc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  salc_dp #(
    .WAYS       (WAYS),
    .SETS       (SETS),
    .LINE_SHIFT (LINE_SHIFT)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_address          (req.address),
    .in_is_store         (req.is_store),
    .out_hit             (rsp.hit),
    .out_demand_filled   (rsp.demand_filled),
    .out_prefetch_filled (rsp.prefetch_filled),
    .out_hit_count       (rsp.hit_count),
    .out_access_count    (rsp.access_count)
  );

endmodule
`default_nettype wire

// ===== src/salc_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/salc_ctrl.sv =====
// Controller state machine of the cache model: sequences clearing, set index
// computation, lookup/update and result delivery. Depends on salc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module salc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output salc_pkg::ctrl_cmd_t       cmd,
  input  wire salc_pkg::dp_stat_t   stat
);
  import salc_pkg::*;

  state_t state;
  state_t state_next;

  // State register and output-valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (stat.clear_last) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_MOD;
      S_MOD:   state_next = S_UPD;
      S_UPD: begin
        if (stat.demand_phase && stat.prefetch_req) state_next = S_MUL1;
        else state_next = S_DONE;
      end
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_MUL1:  cmd.mul1   = 1'b1;
      S_MUL2:  cmd.mul2   = 1'b1;
      S_MOD:   cmd.modr   = 1'b1;
      S_UPD:   cmd.update = 1'b1;
      S_DONE:  cmd.load_out = !out_valid || out_ready;
      default: cmd = '0;
    endcase
  end

`ifndef SYNTH
  // A set update always follows the cycle that issued its read.
  a_upd_after_mod: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |-> $past(state) == S_MOD) else $error("update without read");
  // A new result never overwrites one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready)) else $error("result overwritten");
  // Results appear only from the completion state.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE) else $error("spurious result");
`endif

endmodule
`default_nettype wire

// ===== src/salc_dp.sv =====
// Datapath of the cache model: set index by reciprocal multiply, tag/LRU
// memory, hit and replacement logic, counters, result register.
// Depends on salc_pkg and salc_ram.
`timescale 1ns / 1ps
`default_nettype none
module salc_dp #(
  parameter int WAYS       = salc_pkg::DEF_WAYS,
  parameter int SETS       = salc_pkg::DEF_SETS,
  parameter int LINE_SHIFT = salc_pkg::DEF_LINE_SHIFT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire salc_pkg::ctrl_cmd_t         cmd,
  output salc_pkg::dp_stat_t               stat,
  input  wire logic                        cfg_we,
  input  wire logic [salc_pkg::MODE_W-1:0] cfg_wdata,
  input  wire logic [salc_pkg::ADDR_W-1:0] in_address,
  input  wire logic                        in_is_store,
  output logic                             out_hit,
  output logic                             out_demand_filled,
  output logic                             out_prefetch_filled,
  output logic [salc_pkg::CNT_W-1:0]       out_hit_count,
  output logic [salc_pkg::CNT_W-1:0]       out_access_count
);
  import salc_pkg::*;

  localparam int LINE_W = ADDR_W - LINE_SHIFT;
  localparam int SET_W  = $clog2(SETS);
  localparam int RANK_W = $clog2(WAYS);
  localparam int WAY_W  = 1 + LINE_W + RANK_W;
  localparam int ROW_W  = WAYS * WAY_W;
  localparam logic [LINE_W-1:0] RECIP   = LINE_W'((64'd1 << LINE_W) / SETS);
  localparam logic [LINE_W-1:0] SETS_L  = LINE_W'(SETS);

  mode_t              mode;
  logic [LINE_W-1:0]  line_cur;
  logic               store_r;
  logic               demand_r;
  logic [LINE_W-1:0]  q_est;
  logic [LINE_W-1:0]  prod2;
  logic [SET_W-1:0]   set_idx;
  logic [SET_W-1:0]   clr_idx;
  logic               hit_r;
  logic               dfill_r;
  logic               pfill_r;
  logic [CNT_W-1:0]   hit_cnt;
  logic [CNT_W-1:0]   acc_cnt;

  logic [2*LINE_W-1:0] prod1;
  logic [LINE_W-1:0]   prod2_c;
  logic [LINE_W-1:0]   rem_c;
  logic [LINE_W-1:0]   rem_fix;
  logic [SET_W-1:0]    set_c;
  logic [ROW_W-1:0]    rdata;
  logic [ROW_W-1:0]    new_row;
  logic                ram_we;
  logic [SET_W-1:0]    ram_waddr;
  logic [ROW_W-1:0]    ram_wdata;

  logic [WAYS-1:0]     v;
  logic [LINE_W-1:0]   ln [WAYS];
  logic [RANK_W-1:0]   rk [WAYS];
  logic [WAYS-1:0]     hit_vec;
  logic [WAYS-1:0]     inv_vec;
  logic [WAYS-1:0]     lru_vec;
  logic [RANK_W-1:0]   hit_w;
  logic [RANK_W-1:0]   inv_w;
  logic [RANK_W-1:0]   lru_w;
  logic [RANK_W-1:0]   w;
  logic                hit_c;
  logic                allocate;
  logic                do_touch;
  logic                filled;
  logic [RANK_W:0]     old_rank;
  logic                prefetch_req;

  // Set index: q = line * floor(2^L / SETS) >> L is the quotient or one less.
  assign prod1   = {{LINE_W{1'b0}}, line_cur} * {{LINE_W{1'b0}}, RECIP};
  assign prod2_c = q_est * SETS_L;
  assign rem_c   = line_cur - prod2;
  assign rem_fix = (rem_c >= SETS_L) ? rem_c - SETS_L : rem_c;
  assign set_c   = rem_fix[SET_W-1:0];

  // Unpack the ways of the set read from memory.
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      rk[i]      = rdata[i*WAY_W +: RANK_W];
      ln[i]      = rdata[i*WAY_W + RANK_W +: LINE_W];
      v[i]       = rdata[i*WAY_W + RANK_W + LINE_W];
      hit_vec[i] = v[i] && (ln[i] == line_cur);
      inv_vec[i] = !v[i];
      lru_vec[i] = (rk[i] == RANK_W'(WAYS - 1));
    end
  end

  // Lowest-numbered matching, invalid and least recent ways.
  always_comb begin
    hit_w = '0;
    inv_w = '0;
    lru_w = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_w = RANK_W'(i);
      if (inv_vec[i]) inv_w = RANK_W'(i);
      if (lru_vec[i]) lru_w = RANK_W'(i);
    end
  end

  // Way selection and recency update.
  always_comb begin
    hit_c    = |hit_vec;
    allocate = !(demand_r && mode == MODE_NO_WA && store_r);
    do_touch = hit_c || allocate;
    filled   = !hit_c && allocate;
    if (hit_c) w = hit_w;
    else if (|inv_vec) w = inv_w;
    else w = lru_w;
    old_rank = v[w] ? {1'b0, rk[w]} : (RANK_W + 1)'(WAYS);
    new_row  = rdata;
    if (do_touch) begin
      for (int i = 0; i < WAYS; i++) begin
        if (RANK_W'(i) == w) begin
          new_row[i*WAY_W +: RANK_W]               = '0;
          new_row[i*WAY_W + RANK_W +: LINE_W]      = line_cur;
          new_row[i*WAY_W + RANK_W + LINE_W]       = 1'b1;
        end else if (v[i] && ({1'b0, rk[i]} < old_rank)) begin
          new_row[i*WAY_W +: RANK_W] = rk[i] + 1'b1;
        end
      end
    end
    prefetch_req = (mode == MODE_PF_ALL) || (mode == MODE_PF_MISS && !hit_c);
  end

  assign stat = '{clear_last:   (clr_idx == SET_W'(SETS - 1)),
                  prefetch_req: prefetch_req,
                  demand_phase: demand_r};

  // Memory port: clearing sweep or set write-back.
  assign ram_we    = cmd.clear || cmd.update;
  assign ram_waddr = cmd.clear ? clr_idx : set_idx;
  assign ram_wdata = cmd.clear ? '0 : new_row;

  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (set_c),
    .rdata (rdata)
  );

  // Control-side registers: mode, clear index, counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_ALLOC;
      clr_idx <= '0;
      hit_cnt <= '0;
      acc_cnt <= '0;
    end else begin
      if (cfg_we) mode <= mode_t'(cfg_wdata);
      if (cmd.clear && !stat.clear_last) clr_idx <= clr_idx + 1'b1;
      if (cmd.update && demand_r) begin
        if (hit_c && hit_cnt != '1) hit_cnt <= hit_cnt + 1'b1;
        if (acc_cnt != '1) acc_cnt <= acc_cnt + 1'b1;
      end
    end
  end

  // Payload registers of the lookup sequence and the result.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      line_cur <= in_address[ADDR_W-1:LINE_SHIFT];
      store_r  <= in_is_store;
      demand_r <= 1'b1;
    end
    if (cmd.mul1) q_est <= prod1[2*LINE_W-1:LINE_W];
    if (cmd.mul2) prod2 <= prod2_c;
    if (cmd.modr) set_idx <= set_c;
    if (cmd.update) begin
      if (demand_r) begin
        hit_r   <= hit_c;
        dfill_r <= filled;
        pfill_r <= 1'b0;
        if (prefetch_req) begin
          line_cur <= line_cur + 1'b1;
          demand_r <= 1'b0;
        end
      end else begin
        pfill_r <= filled;
      end
    end
    if (cmd.load_out) begin
      out_hit             <= hit_r;
      out_demand_filled   <= dfill_r;
      out_prefetch_filled <= pfill_r;
      out_hit_count       <= hit_cnt;
      out_access_count    <= acc_cnt;
    end
  end

endmodule
`default_nettype wire
